// ----- src/bci_pkg.sv -----
// Shared types and constants for the breakpoint curve interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bci_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned TickW        = 32;
  localparam int unsigned AmtW         = 16;
  localparam int unsigned LimW         = 15;
  localparam int unsigned CountOutW    = 7;
  localparam int unsigned StatW        = 2;
  localparam int unsigned KindW        = 2;
  localparam logic [LimW-1:0] LimitRst = 15'h7fff;

  typedef enum logic [KindW-1:0] {
    KIND_UPSERT = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic    load_item;
    logic    clr_idx;
    logic    inc_idx;
    logic    rd_idx;
    logic    save_prev;
    logic    set_st;
    status_e st_code;
    logic    val_rd;
    logic    val_prev;
    logic    val_div;
    logic    wr_item;
    logic    sh_from_count;
    logic    sh_from_idx;
    logic    rd_below;
    logic    rd_above;
    logic    wr_shift;
    logic    sh_dec;
    logic    sh_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    div_setup;
    logic    mul;
    logic    div_step;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  over_limit;
    logic  idx_end;
    logic  tick_ge;
    logic  exact;
    logic  full;
    logic  empty;
    logic  idx_zero;
    logic  sh_at_idx;
    logic  sh_last;
    logic  div_last;
  } dp_sts_t;

endpackage

// ----- src/breakpoint_curve_interpolator.sv -----
// Top level of the breakpoint curve interpolator: stream ports, packing, assertions.
// Depends on bci_pkg, bci_ctrl, bci_datapath (and bci_ram below it).
//
// Use: each beat on the s_axis channel is one command. tuser carries the kind
// (upsert, erase, query or none); tdata carries the tick and the signed Q1.15 amount.
// Every command gives exactly one beat on m_axis: status, value, point count.
// The cfg channel writes the amount limit; cfg_ready_o is always high, and it
// should be written only while no command is in flight.
// Sequencing: one command at a time. A command walks the breakpoint RAM one entry
// at a time, reading and then comparing each, until it meets a tick at or above
// its own; an insert or erase then moves the entries behind it one place each,
// and an interpolating query adds a multiply and a 16-step restoring divide.
// The single RAM read port sets the pace.
// The result sits in an output register; a stall on m_axis holds it, and the
// next command is accepted meanwhile, waiting only when its own result is due.
// Reset empties the table and sets the limit to 32767; the RAM is not cleared.
module breakpoint_curve_interpolator #(
  parameter int unsigned MaxPoints = bci_pkg::MaxPointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // tick[31:0], amount[47:32]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[1:0], value[17:2], point_count[24:18]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MaxPoints + 1);

  bci_pkg::dp_cmd_t cmd;
  bci_pkg::dp_sts_t sts;
  logic [bci_pkg::StatW-1:0]     out_status;
  logic [bci_pkg::AmtW-1:0]      out_value;
  logic [bci_pkg::CountOutW-1:0] out_count;
  logic [CW-1:0]                 count;

  assign cfg_ready_o = 1'b1;

  bci_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bci_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .item_kind_i   (s_axis_tuser),
    .item_tick_i   (s_axis_tdata[31:0]),
    .item_amount_i (s_axis_tdata[47:32]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_status_o  (out_status),
    .out_value_o   (out_value),
    .out_count_o   (out_count),
    .count_o       (count)
  );

  assign m_axis_tdata = {7'd0, out_count, out_value, out_status};

  // One command at a time: no second accept right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another is in flight");

  // Table never holds more points than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(MaxPoints))
    else $error("breakpoint count beyond capacity");

  // Count stays unchanged while the controller is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |=> count == $past(count) || !$past(s_axis_tready))
    else $error("breakpoint count changed while idle");

endmodule

// ----- src/bci_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bci_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/bci_datapath.sv -----
// Datapath: breakpoint RAM, scan and shift counters, limit register,
// multiplier and restoring divider, result and output registers. Uses bci_pkg, bci_ram.
module bci_datapath #(
  parameter int unsigned MaxPoints = bci_pkg::MaxPointsDef,
  localparam int unsigned CW = $clog2(MaxPoints + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bci_pkg::dp_cmd_t                 cmd_i,
  output bci_pkg::dp_sts_t                 sts_o,
  input  logic [bci_pkg::KindW-1:0]        item_kind_i,
  input  logic [bci_pkg::TickW-1:0]        item_tick_i,
  input  logic [bci_pkg::AmtW-1:0]         item_amount_i,
  input  logic                             cfg_valid_i,
  input  logic [bci_pkg::LimW-1:0]         cfg_data_i,
  output logic [bci_pkg::StatW-1:0]        out_status_o,
  output logic [bci_pkg::AmtW-1:0]         out_value_o,
  output logic [bci_pkg::CountOutW-1:0]    out_count_o,
  output logic [CW-1:0]                    count_o
);

  localparam int unsigned TW  = bci_pkg::TickW;
  localparam int unsigned AMW = bci_pkg::AmtW;
  localparam int unsigned AW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned EW  = TW + AMW;
  localparam int unsigned DCW = $clog2(AMW);
  localparam int unsigned COW = bci_pkg::CountOutW;

  bci_pkg::kind_e          kind_q;
  bci_pkg::status_e        res_st_q;
  logic [TW-1:0]           tick_q, prev_tick_q, dt_q, width_q, rem_q;
  logic signed [AMW-1:0]   amt_q, prev_amt_q, left_q, res_val_q;
  logic [AMW-1:0]          span_mag_q, quo_q;
  logic                    span_neg_q;
  logic [bci_pkg::LimW-1:0] limit_q;
  logic [CW-1:0]           count_q, idx_q, sh_q;
  logic [DCW-1:0]          div_cnt_q;
  logic [bci_pkg::StatW-1:0] out_st_q;
  logic [AMW-1:0]          out_val_q;
  logic [COW-1:0]          out_cnt_q;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;
  logic [TW-1:0]           rd_tick;
  logic signed [AMW-1:0]   rd_amt;
  logic [CW-1:0]           sh_minus, sh_plus;
  logic [AMW-1:0]          amt_mag;
  logic signed [AMW:0]     span;
  logic [AMW:0]            span_abs;
  logic [TW+AMW-1:0]       prod;
  logic [TW:0]             rem_sh;
  logic [TW+1:0]           diff;
  logic [CW+COW-1:0]       count_ext;

  assign rd_tick  = ram_rdata[TW-1:0];
  assign rd_amt   = signed'(ram_rdata[EW-1:TW]);
  assign sh_minus = sh_q - CW'(1);
  assign sh_plus  = sh_q + CW'(1);

  assign ram_we    = cmd_i.wr_item | cmd_i.wr_shift;
  assign ram_waddr = cmd_i.wr_item ? idx_q[AW-1:0] : sh_q[AW-1:0];
  assign ram_wdata = cmd_i.wr_item ? {amt_q, tick_q} : ram_rdata;
  assign ram_re    = cmd_i.rd_idx | cmd_i.rd_below | cmd_i.rd_above;

  always_comb begin
    ram_raddr = idx_q[AW-1:0];
    if (cmd_i.rd_below) begin
      ram_raddr = sh_minus[AW-1:0];
    end else if (cmd_i.rd_above) begin
      ram_raddr = sh_plus[AW-1:0];
    end
  end

  bci_ram #(.Width(EW), .Depth(MaxPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The most negative amount has magnitude 32768 and always exceeds the limit
  assign amt_mag  = amt_q[AMW-1] ? AMW'(-amt_q) : AMW'(amt_q);
  assign span     = {rd_amt[AMW-1], rd_amt} - {prev_amt_q[AMW-1], prev_amt_q};
  assign span_abs = span[AMW] ? (AMW+1)'(-span) : (AMW+1)'(span);
  assign prod     = span_mag_q * dt_q;
  assign rem_sh   = {rem_q, quo_q[AMW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, width_q};
  assign count_ext = (CW+COW)'(count_q);

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.over_limit = amt_mag > {1'b0, limit_q};
    sts_o.idx_end    = idx_q == count_q;
    sts_o.tick_ge    = rd_tick >= tick_q;
    sts_o.exact      = (idx_q != count_q) && (rd_tick == tick_q);
    sts_o.full       = count_q == CW'(MaxPoints);
    sts_o.empty      = count_q == '0;
    sts_o.idx_zero   = idx_q == '0;
    sts_o.sh_at_idx  = sh_q == idx_q;
    sts_o.sh_last    = sh_plus == count_q;
    sts_o.div_last   = div_cnt_q == DCW'(AMW - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= bci_pkg::LimitRst;
      count_q   <= '0;
      idx_q     <= '0;
      sh_q      <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.sh_from_count) begin
        sh_q <= count_q;
      end else if (cmd_i.sh_from_idx) begin
        sh_q <= idx_q;
      end else if (cmd_i.sh_dec) begin
        sh_q <= sh_minus;
      end else if (cmd_i.sh_inc) begin
        sh_q <= sh_plus;
      end
      if (cmd_i.mul) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q   <= bci_pkg::kind_e'(item_kind_i);
      tick_q   <= item_tick_i;
      amt_q    <= signed'(item_amount_i);
      res_st_q <= bci_pkg::ST_OK;
      res_val_q <= '0;
    end
    if (cmd_i.set_st) begin
      res_st_q <= cmd_i.st_code;
    end
    if (cmd_i.save_prev) begin
      prev_tick_q <= rd_tick;
      prev_amt_q  <= rd_amt;
    end
    if (cmd_i.val_rd) begin
      res_val_q <= rd_amt;
    end else if (cmd_i.val_prev) begin
      res_val_q <= prev_amt_q;
    end else if (cmd_i.val_div) begin
      res_val_q <= span_neg_q ? left_q - signed'(quo_q) : left_q + signed'(quo_q);
    end
    if (cmd_i.div_setup) begin
      left_q     <= prev_amt_q;
      span_neg_q <= span[AMW];
      span_mag_q <= span_abs[AMW-1:0];
      dt_q       <= tick_q - prev_tick_q;
      width_q    <= rd_tick - prev_tick_q;
    end
    // Quotient fits in 16 bits, so the high product half is already below the divisor
    if (cmd_i.mul) begin
      rem_q <= prod[TW+AMW-1:AMW];
      quo_q <= prod[AMW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= diff[TW+1] ? rem_sh[TW-1:0] : diff[TW-1:0];
      quo_q <= {quo_q[AMW-2:0], ~diff[TW+1]};
    end
    if (cmd_i.out_load) begin
      out_st_q  <= res_st_q;
      out_val_q <= res_val_q;
      out_cnt_q <= count_ext[COW-1:0];
    end
  end

  assign out_status_o = out_st_q;
  assign out_value_o  = out_val_q;
  assign out_count_o  = out_cnt_q;
  assign count_o      = count_q;

endmodule

// ----- src/bci_ctrl.sv -----
// Controller: sequences scan, shift, divide and result hand-off for one item.
// Uses bci_pkg; drives bci_datapath through dp_cmd_t.
module bci_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic             m_ready_i,
  output logic             m_valid_o,
  input  bci_pkg::dp_sts_t sts_i,
  output bci_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCAN, S_SCAN_CMP, S_FOUND, S_SHIFT_RD, S_SHIFT_WR,
    S_ERASE_RD, S_ERASE_WR, S_MUL, S_DIV, S_QUOT, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  assign s_ready_o = state_q == S_IDLE;
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    cmd_o.st_code = bci_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.kind == bci_pkg::KIND_NONE) begin
          state_d = S_FINISH;
        end else if (sts_i.kind == bci_pkg::KIND_UPSERT && sts_i.over_limit) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = bci_pkg::ST_LIMIT;
          state_d = S_FINISH;
        end else begin
          cmd_o.clr_idx = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.idx_end) begin
          state_d = S_FOUND;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.tick_ge) begin
          state_d = S_FOUND;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.inc_idx   = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_FOUND: begin
        state_d = S_FINISH;
        case (sts_i.kind)
          bci_pkg::KIND_UPSERT: begin
            if (sts_i.exact) begin
              cmd_o.wr_item = 1'b1;
            end else if (sts_i.full) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = bci_pkg::ST_FULL;
            end else begin
              cmd_o.sh_from_count = 1'b1;
              state_d = S_SHIFT_RD;
            end
          end
          bci_pkg::KIND_ERASE: begin
            if (sts_i.exact) begin
              cmd_o.sh_from_idx = 1'b1;
              state_d = S_ERASE_RD;
            end else begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = bci_pkg::ST_MISSING;
            end
          end
          bci_pkg::KIND_QUERY: begin
            if (sts_i.empty) begin
              state_d = S_FINISH;
            end else if (sts_i.idx_end) begin
              cmd_o.val_prev = 1'b1;
            end else if (sts_i.idx_zero || sts_i.exact) begin
              cmd_o.val_rd = 1'b1;
            end else begin
              cmd_o.div_setup = 1'b1;
              state_d = S_MUL;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      // Open a gap by moving entries up one place, top first
      S_SHIFT_RD: begin
        if (sts_i.sh_at_idx) begin
          cmd_o.wr_item = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_below = 1'b1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.sh_dec   = 1'b1;
        state_d = S_SHIFT_RD;
      end
      // Close the gap by moving entries down one place
      S_ERASE_RD: begin
        if (sts_i.sh_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_above = 1'b1;
          state_d = S_ERASE_WR;
        end
      end
      S_ERASE_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.sh_inc   = 1'b1;
        state_d = S_ERASE_RD;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd_o.val_div = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          m_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule
